// ===== design/bpc_pkg.sv =====
// shared types, constants and period table for the beacon period classifier
package bpc_pkg;

    localparam int NUM_CLASSES_DEF   = 16;
    localparam int CAPTURE_WIDTH_DEF = 32;

    localparam int TIME_W      = 32;
    localparam int CLASS_W     = 4;
    localparam int HELD_W      = 5;
    localparam int TOL_W       = 10;
    localparam int REPEAT_W    = 4;
    localparam int SILENCE_W   = 16;
    localparam int PERIOD_W    = 16;
    localparam int TABLE_DEPTH = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEATS_NEEDED  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT   = 2'd2;

    localparam logic [TOL_W-1:0]     TOL_RESET     = 10'd30;
    localparam logic [REPEAT_W-1:0]  REPEAT_RESET  = 4'd5;
    localparam logic [SILENCE_W-1:0] SILENCE_RESET = 16'd200;

    localparam logic [HELD_W-1:0] NO_CLASS = 5'd16;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    localparam logic KIND_CONFIRMED = 1'b0;
    localparam logic KIND_LOST      = 1'b1;

    localparam int TICKS_PER_US = 40;

    // known periods in capture ticks, longest first
    localparam logic [PERIOD_W-1:0] PERIOD_TABLE [TABLE_DEPTH] = '{
        PERIOD_W'(TICKS_PER_US * 1333), PERIOD_W'(TICKS_PER_US * 1277),
        PERIOD_W'(TICKS_PER_US * 1222), PERIOD_W'(TICKS_PER_US * 1166),
        PERIOD_W'(TICKS_PER_US * 1111), PERIOD_W'(TICKS_PER_US * 1055),
        PERIOD_W'(TICKS_PER_US * 1000), PERIOD_W'(TICKS_PER_US * 944),
        PERIOD_W'(TICKS_PER_US * 889),  PERIOD_W'(TICKS_PER_US * 833),
        PERIOD_W'(TICKS_PER_US * 778),  PERIOD_W'(TICKS_PER_US * 722),
        PERIOD_W'(TICKS_PER_US * 667),  PERIOD_W'(TICKS_PER_US * 611),
        PERIOD_W'(TICKS_PER_US * 556),  PERIOD_W'(TICKS_PER_US * 500)
    };

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] capture_time;
    } in_item_t;

    typedef struct packed {
        logic               report_kind;
        logic [CLASS_W-1:0] class_index;
        logic [HELD_W-1:0]  held_class;
    } out_item_t;

endpackage

// ===== design/beacon_period_classifier_top.sv =====
// beacon period classifier: period measurement, table match, repeat and loss tracking
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+-------------------------------
//  in      | in_valid, in_stall, in_data      | into      | edge capture time or check tick
//  out     | out_valid, out_stall, out_data   | out of    | class confirmed or signal lost
//  cfg     | cfg_valid, cfg_ready, cfg_index, | into      | tolerance, repeats, silence limit
//          | cfg_data                         |           |
//
// one request per cycle while in_stall is low; all work for a request is done in the cycle it is accepted
// a result shows in the output register the cycle after its request is accepted
// in_stall is high only while the output register holds a result and out_stall is high
// reset loads the register defaults and clears all tracking state, no clearing pass
// cfg_ready is always high
module beacon_period_classifier_top #(
    parameter int NUM_CLASSES   = bpc_pkg::NUM_CLASSES_DEF,
    parameter int CAPTURE_WIDTH = bpc_pkg::CAPTURE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bpc_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bpc_pkg::out_item_t                 out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int EXT_W = CAPTURE_WIDTH + 1;

    logic [bpc_pkg::TOL_W-1:0]     tol_reg;
    logic [bpc_pkg::REPEAT_W-1:0]  repeats_reg;
    logic [bpc_pkg::SILENCE_W-1:0] silence_reg;

    logic [CAPTURE_WIDTH-1:0]      prev_capture_reg, prev_capture_next;
    logic [CAPTURE_WIDTH-1:0]      period_reg, period_next;
    logic [bpc_pkg::HELD_W-1:0]    cand_reg, cand_next;
    logic [bpc_pkg::HELD_W-1:0]    prior_reg, prior_next;
    logic [bpc_pkg::REPEAT_W-1:0]  repeat_reg, repeat_next;
    logic [bpc_pkg::HELD_W-1:0]    confirmed_reg, confirmed_next;
    logic [bpc_pkg::SILENCE_W-1:0] ticks_reg, ticks_next;
    logic                          loss_reg, loss_next;

    logic                          out_valid_reg, out_valid_next;
    bpc_pkg::out_item_t            out_data_reg, out_data_next;

    logic                          in_accept;
    logic [CAPTURE_WIDTH-1:0]      cap;
    logic [bpc_pkg::SILENCE_W-1:0] ticks_inc;
    logic                          loss_fire;
    logic [NUM_CLASSES-1:0]        hit;
    logic                          any_hit;
    logic [bpc_pkg::HELD_W-1:0]    hit_idx;
    logic [bpc_pkg::HELD_W-1:0]    cand_cls;
    logic [bpc_pkg::REPEAT_W:0]    count;
    logic                          res_fire;
    bpc_pkg::out_item_t            res;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign cap = in_data.capture_time[CAPTURE_WIDTH-1:0];
    assign ticks_inc = (ticks_reg == {bpc_pkg::SILENCE_W{1'b1}}) ? ticks_reg
                                                                 : ticks_reg + 1'b1;
    assign loss_fire = !loss_reg && (ticks_inc >= silence_reg);

    // open window compare against every table period
    always_comb
    begin
        logic [EXT_W-1:0] p_ext;
        logic [EXT_W-1:0] c_ext;
        logic [EXT_W-1:0] t_ext;
        p_ext = {1'b0, period_reg};
        t_ext = EXT_W'(tol_reg);
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            c_ext  = EXT_W'(bpc_pkg::PERIOD_TABLE[i]);
            hit[i] = (c_ext + t_ext > p_ext) && (c_ext < p_ext + t_ext);
        end
    end

    // first matching entry wins
    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = NUM_CLASSES - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                any_hit = 1'b1;
                hit_idx = bpc_pkg::HELD_W'(i);
            end
        end
    end

    assign cand_cls = any_hit ? hit_idx : cand_reg;
    assign count    = (cand_cls != prior_reg) ? '0
                                              : {1'b0, repeat_reg} + 1'b1;

    always_comb
    begin
        prev_capture_next = prev_capture_reg;
        period_next       = period_reg;
        cand_next         = cand_reg;
        prior_next        = prior_reg;
        repeat_next       = repeat_reg;
        confirmed_next    = confirmed_reg;
        ticks_next        = ticks_reg;
        loss_next         = loss_reg;
        res_fire          = 1'b0;
        res.report_kind   = bpc_pkg::KIND_CONFIRMED;
        res.class_index   = cand_cls[bpc_pkg::CLASS_W-1:0];
        res.held_class    = cand_cls;
        if (in_accept)
        begin
            if (in_data.func == bpc_pkg::FUNC_EDGE)
            begin
                period_next       = cap - prev_capture_reg;
                prev_capture_next = cap;
                ticks_next        = '0;
                loss_next         = 1'b0;
            end
            else
            begin
                ticks_next = ticks_inc;
                if (loss_fire)
                begin
                    loss_next       = 1'b1;
                    cand_next       = bpc_pkg::NO_CLASS;
                    confirmed_next  = bpc_pkg::NO_CLASS;
                    res_fire        = 1'b1;
                    res.report_kind = bpc_pkg::KIND_LOST;
                    res.class_index = '0;
                    res.held_class  = bpc_pkg::NO_CLASS;
                end
                else
                begin
                    cand_next = cand_cls;
                    if (count >= {1'b0, repeats_reg})
                    begin
                        // confirmation leaves the prior candidate untouched
                        repeat_next    = '0;
                        confirmed_next = cand_cls;
                        res_fire       = (cand_cls != bpc_pkg::NO_CLASS);
                    end
                    else
                    begin
                        repeat_next = count[bpc_pkg::REPEAT_W-1:0];
                        prior_next  = cand_cls;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (res_fire)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg     <= bpc_pkg::TOL_RESET;
            repeats_reg <= bpc_pkg::REPEAT_RESET;
            silence_reg <= bpc_pkg::SILENCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpc_pkg::CFG_MATCH_TOLERANCE: tol_reg     <= cfg_data[bpc_pkg::TOL_W-1:0];
                bpc_pkg::CFG_REPEATS_NEEDED:  repeats_reg <= cfg_data[bpc_pkg::REPEAT_W-1:0];
                bpc_pkg::CFG_SILENCE_LIMIT:   silence_reg <= cfg_data[bpc_pkg::SILENCE_W-1:0];
                default:                      tol_reg     <= tol_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_capture_reg <= '0;
            period_reg       <= '0;
            cand_reg         <= bpc_pkg::NO_CLASS;
            prior_reg        <= bpc_pkg::NO_CLASS;
            repeat_reg       <= '0;
            confirmed_reg    <= bpc_pkg::NO_CLASS;
            ticks_reg        <= '0;
            loss_reg         <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            prev_capture_reg <= prev_capture_next;
            period_reg       <= period_next;
            cand_reg         <= cand_next;
            prior_reg        <= prior_next;
            repeat_reg       <= repeat_next;
            confirmed_reg    <= confirmed_next;
            ticks_reg        <= ticks_next;
            loss_reg         <= loss_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // an edge rearms loss detection and restarts the silence count
    a_edge_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (in_data.func == bpc_pkg::FUNC_EDGE)
        |=> !loss_reg && (ticks_reg == '0))
        else $error("edge did not rearm loss tracking");

    // a loss report clears both candidate and confirmed class
    a_loss_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (in_data.func == bpc_pkg::FUNC_TICK) && loss_fire
        |=> loss_reg && (cand_reg == bpc_pkg::NO_CLASS)
            && (confirmed_reg == bpc_pkg::NO_CLASS))
        else $error("loss report left a class behind");

    // a confirmed result always names a real class that is also the held one
    a_confirm_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.report_kind == bpc_pkg::KIND_CONFIRMED)
        |-> (out_data_reg.held_class == {1'b0, out_data_reg.class_index}))
        else $error("confirmed class and held class disagree");

    // a fresh result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled output");

endmodule
